// ===== sv/assert_macros.svh =====
// Assertion macros for the histogram sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define HCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("histogram sampler assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define HCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("histogram sampler assertion failed");

`endif

// ===== sv/hcs_pkg.sv =====
// Package with the types, widths and codes of the histogram sampler.
`timescale 1ns / 1ps
`default_nettype none
package hcs_pkg;
    localparam int MAX_BINS = 65536;
    localparam int ADDR_W   = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int PHI_W    = 9;
    localparam int THETA_W  = 8;
    localparam int PROD_W   = PHI_W + THETA_W;
    localparam int CMP_W    = (PROD_W > CNT_W) ? PROD_W : CNT_W;
    localparam int KIND_W   = 2;
    localparam int WGT_W    = 16;
    localparam int RND_W    = 32;
    localparam int BW_W     = 32;
    localparam int SUM_W    = 48;
    localparam int DCNT_W   = $clog2(ADDR_W + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [KIND_W-1:0] REQ_FILL  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_DRAW  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CHECK = 2'd2;

    localparam logic REG_PHI   = 1'b0;
    localparam logic REG_THETA = 1'b1;

    localparam logic [PHI_W-1:0]   PHI_RST   = 9'd360;
    localparam logic [THETA_W-1:0] THETA_RST = 8'd180;

    typedef struct packed {
        logic [PHI_W-1:0]   eff_phi;
        logic [THETA_W-1:0] eff_theta;
        logic [CNT_W-1:0]   active;
        logic               wr;
    } t_cfg;
endpackage
`default_nettype wire

// ===== sv/weighted_histogram_cdf_sampler_core.sv =====
// Top level of the weighted histogram sampler: sequencer around two bin memories.
//
// Requests enter on start while busy is low; req_type selects fill (0), draw (1)
// or check (2). Each request gives exactly one result, shown on the o_ result
// ports for one cycle with o_valid high; the receiver cannot stall it.
// Fill and check answer after the address, read and wait states, or straight
// after the read state when the bin lies outside the active bins.
// A draw rebuilds the running sums first when they are stale, one memory read per
// active bin. It then reads the total and answers with o_empty_map high when it is
// zero; else it scales the random fraction by the total in a multiply and an add
// step, runs a binary search with a read and a compare state per step and splits
// the found address with the divider.
// An unknown request is answered in the next cycle.
// Configuration is to be written on the APB port only while the block is idle;
// the block does not enforce this. A write marks the running sums stale.
// After reset the weight memory is cleared one entry per cycle, all 65536 entries,
// with busy high; configuration writes are taken during that time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module weighted_histogram_cdf_sampler_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [hcs_pkg::KIND_W-1:0]  i_req_type,
    input  wire logic [hcs_pkg::PHI_W-1:0]   i_phi_index,
    input  wire logic [hcs_pkg::THETA_W-1:0] i_theta_index,
    input  wire logic [hcs_pkg::WGT_W-1:0]   i_weight,
    input  wire logic [hcs_pkg::RND_W-1:0]   i_random_fraction,
    output      logic                        o_valid,
    output      logic [hcs_pkg::KIND_W-1:0]  o_resp_kind,
    output      logic                        o_hit,
    output      logic                        o_empty_map,
    output      logic [hcs_pkg::PHI_W-1:0]   o_drawn_phi,
    output      logic [hcs_pkg::THETA_W-1:0] o_drawn_theta,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [hcs_pkg::PDATA_W-1:0] pwdata,
    output      logic [hcs_pkg::PDATA_W-1:0] prdata,
    output      logic                        pready
);
    import hcs_pkg::*;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_ADDR = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_WAIT = 4'd4;
    localparam logic [3:0] ST_REB  = 4'd5;
    localparam logic [3:0] ST_TOT  = 4'd6;
    localparam logic [3:0] ST_TOTW = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_TGT  = 4'd9;
    localparam logic [3:0] ST_SRD  = 4'd10;
    localparam logic [3:0] ST_SCMP = 4'd11;
    localparam logic [3:0] ST_DIV  = 4'd12;

    t_cfg cfg;

    logic [3:0]          r_state;
    logic [CNT_W-1:0]    r_i;
    logic                r_rv;
    logic [ADDR_W-1:0]   r_ra;
    logic                r_stale;
    logic [KIND_W-1:0]   r_kind;
    logic [PHI_W-1:0]    r_phi;
    logic [THETA_W-1:0]  r_theta;
    logic [WGT_W-1:0]    r_w;
    logic [RND_W-1:0]    r_rnd;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_ok;
    logic [SUM_W-1:0]    r_acc;
    logic [SUM_W-1:0]    r_total;
    logic [SUM_W-1:0]    r_php;
    logic [63:0]         r_plo;
    logic [SUM_W-1:0]    r_target;
    logic [ADDR_W-1:0]   r_lo;
    logic [ADDR_W-1:0]   r_hi;
    logic [ADDR_W-1:0]   r_mid;
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic                r_out_hit;
    logic                r_out_empty;
    logic [PHI_W-1:0]    r_out_phi;
    logic [THETA_W-1:0]  r_out_theta;

    logic                accept;
    logic [PROD_W-1:0]   addr_full;
    logic                addr_ok;
    logic                reb_issue;
    logic [BW_W:0]       fill_sum;
    logic [BW_W-1:0]     fill_val;
    logic [SUM_W:0]      acc_sum;
    logic [SUM_W-1:0]    acc_new;
    logic [ADDR_W:0]     lh_sum;
    logic [ADDR_W-1:0]   mid;
    logic [ADDR_W-1:0]   last_addr;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [BW_W-1:0]     w_wdata;
    logic                w_re;
    logic [ADDR_W-1:0]   w_raddr;
    logic [BW_W-1:0]     w_rdata;
    logic                s_we;
    logic                s_re;
    logic [ADDR_W-1:0]   s_raddr;
    logic [SUM_W-1:0]    s_rdata;

    logic                div_start;
    logic                div_done;
    logic [ADDR_W-1:0]   div_quot;
    logic [PHI_W-1:0]    div_rem;

    hcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hcs_ram #(.DEPTH(MAX_BINS), .WIDTH(BW_W), .AW(ADDR_W)) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hcs_ram #(.DEPTH(MAX_BINS), .WIDTH(SUM_W), .AW(ADDR_W)) u_sums (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_ra),
        .i_wdata (acc_new),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    hcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_lo),
        .i_divisor  (cfg.eff_phi),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign busy      = r_state != ST_IDLE;
    assign accept    = start && !busy;
    assign addr_full = PROD_W'(r_theta) * PROD_W'(cfg.eff_phi) + PROD_W'(r_phi);
    assign addr_ok   = (r_phi < cfg.eff_phi) && (r_theta < cfg.eff_theta)
                       && (CMP_W'(addr_full) < CMP_W'(cfg.active));
    assign reb_issue = (r_state == ST_REB) && (r_i < cfg.active);
    assign fill_sum  = {1'b0, w_rdata} + (BW_W + 1)'(r_w);
    assign fill_val  = fill_sum[BW_W] ? '1 : fill_sum[BW_W-1:0];
    assign acc_sum   = {1'b0, r_acc} + (SUM_W + 1)'(w_rdata);
    assign acc_new   = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    assign lh_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lh_sum[ADDR_W:1];
    assign last_addr = ADDR_W'(cfg.active - CNT_W'(1));

    assign w_we    = (r_state == ST_CLR)
                     || (r_state == ST_WAIT && r_kind == REQ_FILL);
    assign w_waddr = (r_state == ST_CLR) ? r_i[ADDR_W-1:0] : r_addr;
    assign w_wdata = (r_state == ST_CLR) ? '0 : fill_val;
    assign w_re    = reb_issue || (r_state == ST_RD && r_ok);
    assign w_raddr = (r_state == ST_REB) ? r_i[ADDR_W-1:0] : r_addr;
    assign s_we    = (r_state == ST_REB) && r_rv;
    assign s_re    = (r_state == ST_TOT) || (r_state == ST_SRD && r_lo < r_hi);
    assign s_raddr = (r_state == ST_TOT) ? last_addr : mid;
    assign div_start = (r_state == ST_SRD) && !(r_lo < r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_i         <= '0;
            r_rv        <= 1'b0;
            r_stale     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_rv        <= reb_issue;
            if (cfg.wr) begin
                r_stale <= 1'b1;
            end
            case (r_state)
                ST_CLR: begin
                    r_i <= r_i + CNT_W'(1);
                    if (r_i == CNT_W'(MAX_BINS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            REQ_FILL, REQ_CHECK: r_state <= ST_ADDR;
                            REQ_DRAW: begin
                                r_i     <= '0;
                                r_state <= r_stale ? ST_REB : ST_TOT;
                            end
                            default: r_out_valid <= 1'b1;
                        endcase
                    end
                end
                ST_ADDR: r_state <= ST_RD;
                ST_RD: begin
                    if (r_ok) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (r_kind == REQ_FILL) begin
                        r_stale <= 1'b1;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_REB: begin
                    if (reb_issue) begin
                        r_i <= r_i + CNT_W'(1);
                    end else if (!r_rv) begin
                        r_stale <= 1'b0;
                        r_state <= ST_TOT;
                    end
                end
                ST_TOT:  r_state <= ST_TOTW;
                ST_TOTW: begin
                    if (s_rdata == '0) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_TGT;
                ST_TGT:  r_state <= ST_SRD;
                ST_SRD:  r_state <= (r_lo < r_hi) ? ST_SCMP : ST_DIV;
                ST_SCMP: r_state <= ST_SRD;
                ST_DIV: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_req_type;
            r_phi   <= i_phi_index;
            r_theta <= i_theta_index;
            r_w     <= i_weight;
            r_rnd   <= i_random_fraction;
            r_acc   <= '0;
        end
        if (r_state == ST_ADDR) begin
            r_addr <= ADDR_W'(addr_full);
            r_ok   <= addr_ok;
        end
        r_ra <= r_i[ADDR_W-1:0];
        if (s_we) begin
            r_acc <= acc_new;
        end
        if (r_state == ST_TOTW) begin
            r_total <= s_rdata;
        end
        if (r_state == ST_MUL) begin
            r_php <= SUM_W'(r_total[SUM_W-1:32]) * SUM_W'(r_rnd);
            r_plo <= 64'(r_total[31:0]) * 64'(r_rnd);
        end
        if (r_state == ST_TGT) begin
            r_target <= r_php + SUM_W'(r_plo[63:32]);
            r_lo     <= '0;
            r_hi     <= last_addr;
        end
        if (r_state == ST_SRD) begin
            r_mid <= mid;
        end
        if (r_state == ST_SCMP) begin
            if (s_rdata > r_target) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= r_kind;
        r_out_hit   <= 1'b0;
        r_out_empty <= 1'b0;
        r_out_phi   <= '0;
        r_out_theta <= '0;
        if (r_state == ST_IDLE) begin
            r_out_kind <= i_req_type;
        end
        if (r_state == ST_WAIT && r_kind == REQ_CHECK) begin
            r_out_hit <= w_rdata != '0;
        end
        if (r_state == ST_TOTW) begin
            r_out_empty <= s_rdata == '0;
        end
        if (r_state == ST_DIV) begin
            r_out_hit   <= 1'b1;
            r_out_phi   <= div_rem;
            r_out_theta <= THETA_W'(div_quot);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_resp_kind   = r_out_kind;
    assign o_hit         = r_out_hit;
    assign o_empty_map   = r_out_empty;
    assign o_drawn_phi   = r_out_phi;
    assign o_drawn_theta = r_out_theta;

    `HCS_ASSERT_IMP(a_hit_not_empty, i_clk, i_rst_n, r_out_valid && r_out_hit, !r_out_empty)
    `HCS_ASSERT_IMP(a_search_order, i_clk, i_rst_n, r_state == ST_SRD, r_lo <= r_hi)
    `HCS_ASSERT_IMP(a_fill_only_write, i_clk, i_rst_n, w_we && r_state != ST_CLR, r_kind == REQ_FILL)
    `HCS_ASSERT_NXT(a_fill_result, i_clk, i_rst_n, r_state == ST_WAIT, r_out_valid && r_state == ST_IDLE)
endmodule
`default_nettype wire

// ===== sv/hcs_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module hcs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/hcs_cfg.sv =====
// Configuration registers on the APB port and the derived bin counts.
`timescale 1ns / 1ps
`default_nettype none
module hcs_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [hcs_pkg::PDATA_W-1:0] pwdata,
    output      logic [hcs_pkg::PDATA_W-1:0] prdata,
    output      logic                        pready,
    output      hcs_pkg::t_cfg               o_cfg
);
    import hcs_pkg::*;

    logic [PHI_W-1:0]   r_phi;
    logic [THETA_W-1:0] r_theta;
    logic [CNT_W-1:0]   r_active;
    logic               wr_en;
    logic [PHI_W-1:0]   eff_phi;
    logic [THETA_W-1:0] eff_theta;
    logic [PROD_W-1:0]  prod;
    logic [CMP_W-1:0]   prod_ext;
    logic [CNT_W-1:0]   n_active;

    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign eff_phi   = (r_phi == '0) ? PHI_W'(1) : r_phi;
    assign eff_theta = (r_theta == '0) ? THETA_W'(1) : r_theta;
    assign prod      = PROD_W'(eff_phi) * PROD_W'(eff_theta);
    assign prod_ext  = CMP_W'(prod);
    assign n_active  = (prod_ext > CMP_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : CNT_W'(prod_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phi    <= PHI_RST;
            r_theta  <= THETA_RST;
            r_active <= CNT_W'(MAX_BINS);
        end else begin
            r_active <= n_active;
            if (wr_en && paddr[2] == REG_PHI) begin
                r_phi <= pwdata[PHI_W-1:0];
            end
            if (wr_en && paddr[2] == REG_THETA) begin
                r_theta <= pwdata[THETA_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PHI:   prdata = PDATA_W'(r_phi);
            REG_THETA: prdata = PDATA_W'(r_theta);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.eff_phi   = eff_phi;
    assign o_cfg.eff_theta = eff_theta;
    assign o_cfg.active    = r_active;
    assign o_cfg.wr        = wr_en;
endmodule
`default_nettype wire

// ===== sv/hcs_div.sv =====
// Restoring divider, one quotient bit per cycle, for splitting a bin address.
`timescale 1ns / 1ps
`default_nettype none
module hcs_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [hcs_pkg::ADDR_W-1:0]  i_dividend,
    input  wire logic [hcs_pkg::PHI_W-1:0]   i_divisor,
    output      logic                        o_done,
    output      logic [hcs_pkg::ADDR_W-1:0]  o_quot,
    output      logic [hcs_pkg::PHI_W-1:0]   o_rem
);
    import hcs_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DCNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  r_quot;
    logic [PHI_W-1:0]   r_rem;
    logic [PHI_W-1:0]   r_div;
    logic [PHI_W:0]     trial;
    logic               bit_q;

    assign trial = {r_rem, r_quot[ADDR_W-1]};
    assign bit_q = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(ADDR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= ADDR_W'({r_quot, bit_q});
            r_rem  <= bit_q ? PHI_W'(trial - {1'b0, r_div}) : PHI_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire
